### rtl/sfss_pkg.sv
// ============================================================================
// sfss_pkg - shared types and constants of the seven-segment scanner
// Character codes, symbol codes, pipeline operation codes and the request
// record handed from the decode stage to the store stage.
// ============================================================================
package sfss_pkg;

	// Default number of visible digits.
	localparam int DIGIT_COUNT_DEF = 5;

	// Fixed field widths.
	localparam int BYTE_W  = 8;
	localparam int CODE_W  = 7;
	localparam int SEL_W   = 5;
	localparam int SHIFT_W = 8;
	localparam int TDATA_W = 16;

	// Received characters with a meaning of their own.
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_I     = 8'h49;
	localparam logic [BYTE_W-1:0] LETTER_OFS = 8'h37;
	localparam logic [BYTE_W-1:0] BRIGHT_LO  = 8'h4E;
	localparam logic [BYTE_W-1:0] BRIGHT_HI  = 8'hFE;

	// Symbol code for any other byte above the letter range.
	localparam logic [CODE_W-1:0] CODE_FILL = 7'd11;

	// Point bit inside a store entry.
	localparam logic [BYTE_W-1:0] POINT_MASK = 8'h80;

	// Brightness and compare value after reset.
	localparam logic [BYTE_W-1:0] BRIGHT_RESET = 8'd254;

	// Store operation carried by a beat into the second stage.
	typedef logic [1:0] op_t;
	localparam op_t OP_NONE   = 2'd0;
	localparam op_t OP_WRITE  = 2'd1;
	localparam op_t OP_TOGGLE = 2'd2;
	localparam op_t OP_SHOW   = 2'd3;

	// Request from the decode stage to the store stage.
	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] code;
		logic [SEL_W-1:0]  select;
		logic              lit;
	} req_t;

endpackage

### rtl/sfss_ram.sv
// ============================================================================
// sfss_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. A read at the address being
// written returns the old contents.
// ============================================================================
module sfss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 6
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/sfss_front.sv
// ============================================================================
// sfss_front - beat decode and scalar display state
// Decodes each accepted beat, updates the write index, brightness, timer,
// scan position, select and lit flag, and issues the store read.
// ============================================================================
module sfss_front #(
	parameter int DIGIT_COUNT = sfss_pkg::DIGIT_COUNT_DEF,
	parameter int IDX_W       = $clog2(DIGIT_COUNT + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  logic                        mode,
	input  logic [sfss_pkg::BYTE_W-1:0] rx_byte,
	output sfss_pkg::req_t              req,
	output logic [IDX_W-1:0]            addr
);

	import sfss_pkg::*;

	logic [IDX_W-1:0]   wi_q, wi_n;
	logic [IDX_W-1:0]   pos_q, pos_n;
	logic [BYTE_W-1:0]  br_q, br_n;
	logic [BYTE_W-1:0]  cmp_q, cmp_n;
	logic [BYTE_W-1:0]  tc_q, tc_n;
	logic [SEL_W-1:0]   sel_q, sel_n;
	logic               lit_q, lit_n;
	logic [IDX_W-1:0]   wi_inc;
	logic [IDX_W-1:0]   shift;
	logic [SHIFT_W-1:0] sel_wide;

	// Next write index after a byte that moves it on.
	assign wi_inc = (wi_q == IDX_W'(DIGIT_COUNT)) ? '0 : wi_q + 1'b1;

	// First position sits in the highest select bit.
	assign shift    = IDX_W'(DIGIT_COUNT - 1) - pos_q;
	assign sel_wide = SHIFT_W'(1) << shift;

	// Decode of one beat against the current state.
	always_comb begin
		wi_n     = wi_q;
		pos_n    = pos_q;
		br_n     = br_q;
		cmp_n    = cmp_q;
		tc_n     = tc_q;
		sel_n    = sel_q;
		lit_n    = lit_q;
		req.op   = OP_NONE;
		req.code = '0;
		addr     = wi_q;
		if (mode) begin
			tc_n = tc_q + 1'b1;
			if (tc_q == 8'hFF) begin
				cmp_n  = br_q;
				req.op = OP_SHOW;
				addr   = pos_q;
				sel_n  = sel_wide[SEL_W-1:0];
				lit_n  = 1'b1;
				pos_n  = (pos_q == IDX_W'(DIGIT_COUNT - 1)) ? '0 : pos_q + 1'b1;
			end
			if (tc_n == cmp_n) begin
				lit_n = 1'b0;
			end
		end else begin
			priority if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
				wi_n = '0;
			end else if (rx_byte >= BRIGHT_LO && rx_byte <= BRIGHT_HI) begin
				br_n = rx_byte;
			end else if (rx_byte == CHAR_POINT) begin
				// A point with nothing before it is dropped.
				if (wi_q != '0) begin
					req.op = OP_TOGGLE;
					addr   = wi_q - 1'b1;
				end
			end else if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
				req.op   = OP_WRITE;
				req.code = CODE_W'(rx_byte - CHAR_ZERO);
				wi_n     = wi_inc;
			end else if (rx_byte >= CHAR_A && rx_byte <= CHAR_I) begin
				req.op   = OP_WRITE;
				req.code = CODE_W'(rx_byte - LETTER_OFS);
				wi_n     = wi_inc;
			end else if (rx_byte > CHAR_I) begin
				req.op   = OP_WRITE;
				req.code = CODE_FILL;
				wi_n     = wi_inc;
			end else begin
				// Unmapped byte: no entry, index still moves on.
				wi_n = wi_inc;
			end
		end
		req.select = sel_n;
		req.lit    = lit_n;
	end

	// Scalar state advances on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q  <= '0;
			pos_q <= '0;
			br_q  <= BRIGHT_RESET;
			cmp_q <= BRIGHT_RESET;
			tc_q  <= '0;
			sel_q <= '0;
			lit_q <= 1'b0;
		end else if (acc) begin
			wi_q  <= wi_n;
			pos_q <= pos_n;
			br_q  <= br_n;
			cmp_q <= cmp_n;
			tc_q  <= tc_n;
			sel_q <= sel_n;
			lit_q <= lit_n;
		end
	end

endmodule

### rtl/sfss_back.sv
// ============================================================================
// sfss_back - store read-modify-write stage and output register
// Takes the read data of the digit store, forwards the write of the beat
// ahead, writes codes and point toggles back, and holds the result beat.
// ============================================================================
module sfss_back #(
	parameter int DEPTH = sfss_pkg::DIGIT_COUNT_DEF + 1,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  sfss_pkg::req_t               req,
	input  logic [IDX_W-1:0]             rd_addr,
	input  logic [sfss_pkg::BYTE_W-1:0]  rd_data,
	output logic                         wr_en,
	output logic [IDX_W-1:0]             wr_addr,
	output logic [sfss_pkg::BYTE_W-1:0]  wr_data,
	output logic                         in_ready,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [sfss_pkg::TDATA_W-1:0] m_tdata
);

	import sfss_pkg::*;

	logic              s1_valid_q;
	req_t              req_s1;
	logic [IDX_W-1:0]  addr_s1;
	logic              vld_s1;
	logic              fwd_s1;
	logic [BYTE_W-1:0] fwd_data_s1;
	logic [DEPTH-1:0]  valid_q;
	logic [BYTE_W-1:0] shown_q;
	logic [BYTE_W-1:0] entry;
	logic [BYTE_W-1:0] shown_n;
	logic              s1_adv;
	logic              out_valid_q;
	logic [SEL_W-1:0]  sel_q;
	logic [BYTE_W-1:0] out_entry_q;
	logic              lit_q;

	// The stage moves on when the output register is free or being taken.
	assign s1_adv   = s1_valid_q && (!out_valid_q || m_tready);
	assign in_ready = !s1_valid_q || s1_adv;

	// Entry as seen by this beat: forwarded, stored, or never written.
	always_comb begin
		if (fwd_s1) begin
			entry = fwd_data_s1;
		end else if (vld_s1) begin
			entry = rd_data;
		end else begin
			entry = '0;
		end
	end

	// Write-back of codes and point toggles.
	assign wr_en   = s1_adv && (req_s1.op == OP_WRITE || req_s1.op == OP_TOGGLE);
	assign wr_addr = addr_s1;
	assign wr_data = (req_s1.op == OP_TOGGLE) ? (entry ^ POINT_MASK)
		: {1'b0, req_s1.code};

	// Shown entry after this beat.
	assign shown_n = (req_s1.op == OP_SHOW) ? entry : shown_q;

	// Stage register, loaded with each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Payload of the stage, with the forwarding decision taken at accept.
	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1      <= req;
			addr_s1     <= rd_addr;
			vld_s1      <= valid_q[rd_addr];
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	// Entries not yet written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Latched display entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
		end else if (s1_adv) begin
			shown_q <= shown_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			sel_q       <= req_s1.select;
			out_entry_q <= shown_n;
			lit_q       <= req_s1.lit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, lit_q, out_entry_q, sel_q};

endmodule

### rtl/serial_fed_seven_segment_scanner.sv
// ============================================================================
// serial_fed_seven_segment_scanner - serial-fed multiplexed display scanner
// Serial bytes edit a small digit store; timer ticks scan the digits and
// time the brightness on-window of each digit period.
// ============================================================================
// Path: a taken input beat passes through the stage register into the output register.
// Throughput: one beat per cycle while the output register is free or being taken;
// the store read-modify-write spans the two stages, with the write of the beat ahead forwarded to the read.
// Reset: arst_n clears all control state at once; brightness and compare
// start at 254, every store entry reads as zero until written.
module serial_fed_seven_segment_scanner #(
	parameter int DIGIT_COUNT = sfss_pkg::DIGIT_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [sfss_pkg::BYTE_W-1:0]  s_tdata,  // [7:0] rx_byte
	input  logic                         s_tuser,  // [0] mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [4:0] digit_select, [11:5] digit_code, [12] point_on, [13] segments_lit
	output logic [sfss_pkg::TDATA_W-1:0] m_tdata
);

	import sfss_pkg::*;

	localparam int DEPTH = DIGIT_COUNT + 1;
	localparam int IDX_W = $clog2(DEPTH);

	logic              acc;
	req_t              req;
	logic [IDX_W-1:0]  rd_addr;
	logic [BYTE_W-1:0] rd_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [BYTE_W-1:0] wr_data;

	assign acc = s_tvalid && s_tready;

	// Decode and scalar state.
	sfss_front #(
		.DIGIT_COUNT(DIGIT_COUNT),
		.IDX_W      (IDX_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.mode   (s_tuser),
		.rx_byte(s_tdata),
		.req    (req),
		.addr   (rd_addr)
	);

	// Digit store.
	sfss_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (acc),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Read-modify-write and output register.
	sfss_back #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.req     (req),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.in_ready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

### rtl/sfss_checker.sv
// ============================================================================
// sfss_checker - port-level checks of the seven-segment scanner
// Tracks beats in flight and checks the output channel against them.
// ============================================================================
module sfss_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [sfss_pkg::TDATA_W-1:0] m_tdata
);

	import sfss_pkg::*;

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Beats taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// A stalled result beat holds its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// No result without a beat behind it, and at most two in flight.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0 && pending_q != 2'd3)
		else $error("result beat without matching input beat");

	// With the output register empty, the input is always ready.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register empty");

	// At most one digit is driven.
	a_select: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[SEL_W-1:0]))
		else $error("more than one digit selected");

endmodule

bind serial_fed_seven_segment_scanner sfss_checker u_sfss_checker (.*);
